FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers sampled on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MDC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define MDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg
// Shared types and constants of the mail domain classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package mdc_pkg;

	localparam logic [7:0] CHR_HASH = 8'h23;
	localparam logic [7:0] CHR_DASH = 8'h2D;
	localparam logic [7:0] CHR_DOT = 8'h2E;
	localparam logic [7:0] CHR_ZERO = 8'h30;
	localparam logic [7:0] CHR_NINE = 8'h39;
	localparam logic [7:0] CHR_UPPER_A = 8'h41;
	localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHR_LOWER_A = 8'h61;
	localparam logic [7:0] CHR_LOWER_Z = 8'h7A;

	localparam logic [9:0] OCTET_MAX = 10'd255;
	localparam logic [1:0] OCTET_DIGITS_MAX = 2'd3;
	localparam logic [1:0] OCTET_LAST = 2'd3;
	localparam logic [7:0] MAX_LEN_RESET = 8'd255;

	localparam logic [1:0] KIND_NAME = 2'd0;
	localparam logic [1:0] KIND_NUMBER = 2'd1;
	localparam logic [1:0] KIND_IPV4 = 2'd2;

	localparam int MID_DEPTH = 4;
	localparam int MID_AW = $clog2(MID_DEPTH);
	localparam int MID_CW = $clog2(MID_DEPTH + 1);

	typedef enum logic [2:0] {
		CLS_LETTER,
		CLS_DIGIT,
		CLS_HASH,
		CLS_DOT,
		CLS_DASH,
		CLS_OTHER
	} cls_t;

	typedef enum logic [1:0] {
		MODE_BEGIN,
		MODE_NAME,
		MODE_NUMBER,
		MODE_IP
	} mode_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		cls_t       cls;
		logic [3:0] digit;
		logic       last;
	} mid_word_t;

	typedef struct packed {
		logic        store_char;
		logic [7:0]  store_index;
		logic        done_res;
		logic        accepted;
		logic [1:0]  domain_kind;
		logic [31:0] ipv4_address;
		logic [7:0]  text_length;
	} out_word_t;

endpackage

`default_nettype wire

FILE: rtl/mdc_front.sv
// ----------------------------------------------------------------------------
// mdc_front
// Input side: accepts text bytes and reduces each to a character class word.
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_front import mdc_pkg::*; (
	input  wire logic      push,
	output logic           full,
	input  wire in_word_t  item,
	input  wire logic      mid_full,
	output logic           mid_push,
	output mid_word_t      mid_wdata
);

	logic [7:0] b;
	logic       is_letter;
	logic       is_digit;

	assign b = item.text_byte;
	assign is_letter = (b >= CHR_UPPER_A && b <= CHR_UPPER_Z) ||
		(b >= CHR_LOWER_A && b <= CHR_LOWER_Z);
	assign is_digit = (b >= CHR_ZERO && b <= CHR_NINE);

	always_comb begin
		mid_wdata.digit = b[3:0];
		mid_wdata.last = item.last_byte;
		priority if (is_letter) begin
			mid_wdata.cls = CLS_LETTER;
		end else if (is_digit) begin
			mid_wdata.cls = CLS_DIGIT;
		end else if (b == CHR_HASH) begin
			mid_wdata.cls = CLS_HASH;
		end else if (b == CHR_DOT) begin
			mid_wdata.cls = CLS_DOT;
		end else if (b == CHR_DASH) begin
			mid_wdata.cls = CLS_DASH;
		end else begin
			mid_wdata.cls = CLS_OTHER;
		end
	end

	assign full = mid_full;
	assign mid_push = push && !mid_full;

endmodule

`default_nettype wire

FILE: rtl/mdc_queue.sv
// ----------------------------------------------------------------------------
// mdc_queue
// Short queue of class words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_queue import mdc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_en,
	input  wire mid_word_t  wr_data,
	output logic            full,
	input  wire logic       rd_en,
	output mid_word_t       rd_data,
	output logic            empty
);

	mid_word_t          mem_q [MID_DEPTH];
	logic [MID_AW-1:0]  wr_ptr_q;
	logic [MID_AW-1:0]  rd_ptr_q;
	logic [MID_CW-1:0]  count_q;
	logic               do_wr;
	logic               do_rd;

	assign full = (count_q == MID_CW'(MID_DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/mdc_back.sv
// ----------------------------------------------------------------------------
// mdc_back
// Parse state machine, octet accumulation and a two-entry result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_back import mdc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       mid_empty,
	input  wire mid_word_t  mid_rdata,
	output logic            mid_pop,
	input  wire logic       pop,
	output logic            empty,
	output out_word_t       result
);

	logic [7:0]  maxlen_q;
	mode_t       mode_q;
	logic        err_q;
	logic [9:0]  oval_q;
	logic [1:0]  odig_q;
	logic [1:0]  onum_q;
	logic [31:0] addr_q;
	logic [7:0]  cnt_q;

	mode_t       p_mode;
	logic        p_err;
	logic [9:0]  p_oval;
	logic [1:0]  p_odig;
	logic [1:0]  p_onum;
	logic [31:0] p_addr;
	logic [7:0]  p_cnt;
	logic        st;
	logic [7:0]  ix;

	out_word_t   res;
	out_word_t   obuf_q [2];
	logic        head_q;
	logic [1:0]  ocnt_q;
	logic        out_pop;
	logic        take;
	logic        tail;

	assign out_pop = pop && (ocnt_q != 2'd0);
	assign take = !mid_empty && ((ocnt_q != 2'd2) || out_pop);
	assign mid_pop = take;
	assign empty = (ocnt_q == 2'd0);
	assign result = obuf_q[head_q];
	assign tail = head_q ^ ocnt_q[0];

	// Next state of the parser for the word at the head of the queue.
	always_comb begin
		logic want_store;
		logic want_digit;
		logic oct_ok;
		want_store = 1'b0;
		want_digit = 1'b0;
		oct_ok = (odig_q != 2'd0) && (oval_q <= OCTET_MAX);
		p_mode = mode_q;
		p_err = err_q;
		p_oval = oval_q;
		p_odig = odig_q;
		p_onum = onum_q;
		p_addr = addr_q;
		p_cnt = cnt_q;
		st = 1'b0;
		ix = 8'd0;
		if (!err_q) begin
			unique case (mode_q)
				MODE_BEGIN: begin
					priority if (mid_rdata.cls == CLS_HASH) begin
						p_mode = MODE_NUMBER;
						want_store = 1'b1;
					end else if (mid_rdata.cls == CLS_LETTER) begin
						p_mode = MODE_NAME;
						want_store = 1'b1;
					end else if (mid_rdata.cls == CLS_DIGIT) begin
						p_mode = MODE_IP;
						want_digit = 1'b1;
					end else begin
						p_err = 1'b1;
					end
				end
				MODE_NAME: begin
					if (mid_rdata.cls == CLS_LETTER || mid_rdata.cls == CLS_DIGIT ||
						((mid_rdata.cls == CLS_DOT || mid_rdata.cls == CLS_DASH) &&
						!mid_rdata.last)) begin
						want_store = 1'b1;
					end else begin
						p_err = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (mid_rdata.cls == CLS_DIGIT ||
						(mid_rdata.cls == CLS_DOT && !mid_rdata.last)) begin
						want_store = 1'b1;
					end else begin
						p_err = 1'b1;
					end
				end
				MODE_IP: begin
					priority if (mid_rdata.cls == CLS_DIGIT) begin
						want_digit = 1'b1;
					end else if (mid_rdata.cls == CLS_DOT && !mid_rdata.last && oct_ok &&
						onum_q != OCTET_LAST) begin
						p_addr = {addr_q[23:0], oval_q[7:0]};
						p_onum = onum_q + 1'b1;
						p_oval = 10'd0;
						p_odig = 2'd0;
					end else begin
						p_err = 1'b1;
					end
				end
				default: begin
					p_err = 1'b1;
				end
			endcase
		end
		if (want_store) begin
			if (cnt_q >= maxlen_q) begin
				p_err = 1'b1;
			end else begin
				st = 1'b1;
				ix = cnt_q;
				p_cnt = cnt_q + 1'b1;
			end
		end
		if (want_digit) begin
			if (odig_q >= OCTET_DIGITS_MAX) begin
				p_err = 1'b1;
			end else begin
				p_oval = {oval_q[6:0], 3'b000} + {oval_q[8:0], 1'b0} +
					{6'd0, mid_rdata.digit};
				p_odig = odig_q + 1'b1;
			end
		end
	end

	// Result word for the same input word.
	always_comb begin
		res.store_char = st;
		res.store_index = ix;
		res.done_res = mid_rdata.last;
		res.accepted = 1'b0;
		res.domain_kind = KIND_NAME;
		res.ipv4_address = 32'd0;
		res.text_length = 8'd0;
		if (mid_rdata.last && !p_err) begin
			if (p_mode == MODE_NAME || p_mode == MODE_NUMBER) begin
				res.accepted = 1'b1;
				res.domain_kind = (p_mode == MODE_NAME) ? KIND_NAME : KIND_NUMBER;
				res.text_length = p_cnt;
			end else if (p_mode == MODE_IP && p_onum == OCTET_LAST && p_odig != 2'd0 &&
				p_oval <= OCTET_MAX) begin
				res.accepted = 1'b1;
				res.domain_kind = KIND_IPV4;
				res.ipv4_address = {p_addr[23:0], p_oval[7:0]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			obuf_q[tail] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxlen_q <= MAX_LEN_RESET;
			mode_q <= MODE_BEGIN;
			err_q <= 1'b0;
			oval_q <= 10'd0;
			odig_q <= 2'd0;
			onum_q <= 2'd0;
			addr_q <= 32'd0;
			cnt_q <= 8'd0;
			head_q <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (cfg_we) begin
				maxlen_q <= cfg_wdata;
			end
			if (take) begin
				if (mid_rdata.last) begin
					mode_q <= MODE_BEGIN;
					err_q <= 1'b0;
					oval_q <= 10'd0;
					odig_q <= 2'd0;
					onum_q <= 2'd0;
					addr_q <= 32'd0;
					cnt_q <= 8'd0;
				end else begin
					mode_q <= p_mode;
					err_q <= p_err;
					oval_q <= p_oval;
					odig_q <= p_odig;
					onum_q <= p_onum;
					addr_q <= p_addr;
					cnt_q <= p_cnt;
				end
			end
			if (out_pop) begin
				head_q <= ~head_q;
			end
			if (take && !out_pop) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (out_pop && !take) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/mail_domain_classifier.sv
// ----------------------------------------------------------------------------
// mail_domain_classifier
// Classifies a mail domain byte by byte as host name, number form or IPv4.
// ----------------------------------------------------------------------------
// Channel   Ports                  Handshake
// input     item, push, full       word taken when push and not full
// result    result, empty, pop     word taken when pop and not empty
// config    cfg_wdata, cfg_we      written when cfg_we
//
// One input word enters per cycle while full is low; each yields one result word.
// A word crosses the front into a four-entry queue, then the parser in the
// back writes its result into a two-entry output buffer, and the result word
// shows on the result ports from that buffer once both have registered it.
// Reset clears all control state and sets the length limit to 255.
// A stalled result side fills the buffer, then the queue, then raises full.
// ----------------------------------------------------------------------------
`default_nettype none

module mail_domain_classifier import mdc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire in_word_t   item,
	output logic            empty,
	input  wire logic       pop,
	output out_word_t       result,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);

	logic      mid_full;
	logic      mid_push;
	mid_word_t mid_wdata;
	logic      mid_empty;
	logic      mid_pop;
	mid_word_t mid_rdata;

	mdc_front u_front (
		.push      (push),
		.full      (full),
		.item      (item),
		.mid_full  (mid_full),
		.mid_push  (mid_push),
		.mid_wdata (mid_wdata)
	);

	mdc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_push),
		.wr_data (mid_wdata),
		.full    (mid_full),
		.rd_en   (mid_pop),
		.rd_data (mid_rdata),
		.empty   (mid_empty)
	);

	mdc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.mid_empty (mid_empty),
		.mid_rdata (mid_rdata),
		.mid_pop   (mid_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

`default_nettype wire

FILE: rtl/mdc_checker.sv
// ----------------------------------------------------------------------------
// mdc_port_checks
// Port-level checks of the result words of the classifier.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mdc_port_checks import mdc_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire out_word_t  result
);

	logic shown;
	logic is_ipv4;
	logic verdict_clear;

	assign shown = !empty;
	assign is_ipv4 = (result.domain_kind == KIND_IPV4);
	assign verdict_clear = (result.domain_kind == KIND_NAME) &&
		(result.ipv4_address == 32'd0) && (result.text_length == 8'd0);

	`MDC_ASSERT_NEXT(a_result_held, shown && !pop, shown && $stable(result), "result moved in a stall")
	`MDC_ASSERT(a_accept_on_last, shown && result.accepted |-> result.done_res, "early verdict")
	`MDC_ASSERT(a_index_idle, shown && !result.store_char |-> result.store_index == 8'd0, "stray index")
	`MDC_ASSERT(a_reject_clean, shown && !result.accepted |-> verdict_clear, "rejected word has a verdict")
	`MDC_ASSERT(a_ipv4_nolen, shown && is_ipv4 |-> result.text_length == 8'd0, "address with length")

endmodule

bind mail_domain_classifier mdc_port_checks u_port_checks (.*);

`default_nettype wire
